[rtl/ifdyu_pkg.sv]
// shared constants and types for the imu frame decoder with yaw unwrap
// no dependencies; used by every rtl file of the block except the checker

package ifdyu_pkg;

    localparam int FRAME_BYTES = 20;
    localparam int SUM_BYTES   = FRAME_BYTES - 1;
    localparam int WORD_COUNT  = 9;
    localparam int YAW_WORD    = 2;
    localparam int POS_W       = $clog2(FRAME_BYTES + 1);
    localparam int TURN_BITS   = 12;
    localparam int OFFSET_W    = 17;
    localparam int UNWRAP_W    = 32;

    localparam logic signed [15:0] WRAP_LIMIT = 16'sd15000;
    localparam logic signed [UNWRAP_W-1:0] TURN_SPAN = 32'sd36000;
    localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
    localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};

    typedef logic [SUM_BYTES-1:0][7:0]  frame_bytes_t;
    typedef logic [WORD_COUNT-1:0][15:0] held_words_t;

    typedef struct packed {
        logic         fire;
        logic         ok;
        frame_bytes_t bytes;
    } frame_evt_t;

endpackage

[rtl/ifdyu_if.sv]
// channel interfaces: frame bytes in, decoded results out, yaw offset config
// depends on ifdyu_pkg for field widths

interface imu_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface imu_result_if;
    logic               valid;
    logic               ready;
    logic               frame_ok;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic signed [15:0] roll_speed;
    logic signed [15:0] pitch_speed;
    logic signed [15:0] yaw_speed;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [7:0]         sample_index;
    logic signed [ifdyu_pkg::UNWRAP_W-1:0] unwrapped_yaw;

    modport source (output valid, output frame_ok, output roll, output pitch, output yaw,
                    output roll_speed, output pitch_speed, output yaw_speed, output accel_x,
                    output accel_y, output accel_z, output sample_index,
                    output unwrapped_yaw, input ready);
    modport sink   (input valid, input frame_ok, input roll, input pitch, input yaw,
                    input roll_speed, input pitch_speed, input yaw_speed, input accel_x,
                    input accel_y, input accel_z, input sample_index,
                    input unwrapped_yaw, output ready);
endinterface

interface imu_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ifdyu_pkg::OFFSET_W-1:0] yaw_offset;

    modport source (output valid, output yaw_offset, input ready);
    modport sink   (input valid, input yaw_offset, output ready);
endinterface

[rtl/ifdyu_assemble.sv]
// byte position, running checksum and staging registers for one frame
// depends on ifdyu_pkg

module ifdyu_assemble (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [7:0]             data_byte,
    input  logic                   frame_start,
    output ifdyu_pkg::frame_evt_t  evt
);
    import ifdyu_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next, pos_eff;
    logic [7:0]       sum_reg, sum_next, sum_eff;
    frame_bytes_t     staged_reg;
    logic             stage_wr;

    always_comb
    begin
        pos_eff  = frame_start ? '0 : pos_reg;
        sum_eff  = frame_start ? '0 : sum_reg;
        pos_next = pos_reg;
        sum_next = sum_reg;
        stage_wr = 1'b0;
        evt.fire = 1'b0;
        evt.ok   = (sum_eff == data_byte);
        evt.bytes = staged_reg;
        if (accept)
        begin
            pos_next = pos_eff;
            sum_next = sum_eff;
            if (pos_eff < POS_W'(SUM_BYTES))
            begin
                stage_wr = 1'b1;
                sum_next = sum_eff + data_byte;
                pos_next = pos_eff + 1'b1;
            end
            else if (pos_eff == POS_W'(SUM_BYTES))
            begin
                pos_next = POS_W'(FRAME_BYTES);
                evt.fire = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SUM_BYTES; i++)
        begin
            if (stage_wr && pos_eff == POS_W'(i))
            begin
                staged_reg[i] <= data_byte;
            end
        end
    end

endmodule

[rtl/ifdyu_unwrap.sv]
// held values, turn counter and result register
// depends on ifdyu_pkg and the frame event from ifdyu_assemble

module ifdyu_unwrap (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ifdyu_pkg::frame_evt_t                 evt,
    input  logic signed [ifdyu_pkg::OFFSET_W-1:0] yaw_offset,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic                                  frame_ok,
    output ifdyu_pkg::held_words_t                held_words,
    output logic [7:0]                            sample_index,
    output logic signed [ifdyu_pkg::UNWRAP_W-1:0] unwrapped_yaw
);
    import ifdyu_pkg::*;

    held_words_t                  held_reg, held_next, frame_words;
    logic [7:0]                   index_reg, index_next;
    logic signed [15:0]           prev_reg, yaw_n;
    logic signed [TURN_BITS-1:0]  turn_reg, turn_next;
    logic signed [UNWRAP_W-1:0]   span_reg, span_next;
    logic signed [UNWRAP_W-1:0]   unwrap_reg, unwrap_next;
    logic                         valid_reg, ok_reg;
    logic                         wrap_up, wrap_dn;

    always_comb
    begin
        for (int i = 0; i < WORD_COUNT; i++)
        begin
            frame_words[i] = {evt.bytes[2*i+1], evt.bytes[2*i]};
        end
        held_next  = evt.ok ? frame_words : held_reg;
        index_next = evt.ok ? evt.bytes[SUM_BYTES-1] : index_reg;
        yaw_n      = signed'(held_next[YAW_WORD]);
        wrap_up    = (yaw_n < -WRAP_LIMIT) && (prev_reg > WRAP_LIMIT) && (turn_reg != TURN_MAX);
        wrap_dn    = (yaw_n > WRAP_LIMIT) && (prev_reg < -WRAP_LIMIT) && (turn_reg != TURN_MIN);
        turn_next  = turn_reg;
        span_next  = span_reg;
        if (wrap_up)
        begin
            turn_next = turn_reg + 1'b1;
            span_next = span_reg + TURN_SPAN;
        end
        else if (wrap_dn)
        begin
            turn_next = turn_reg - 1'b1;
            span_next = span_reg - TURN_SPAN;
        end
        unwrap_next = UNWRAP_W'(yaw_n) + span_next + UNWRAP_W'(yaw_offset);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= '0;
            index_reg <= '0;
            prev_reg  <= '0;
            turn_reg  <= '0;
            span_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else if (evt.fire)
        begin
            held_reg  <= held_next;
            index_reg <= index_next;
            prev_reg  <= yaw_n;
            turn_reg  <= turn_next;
            span_reg  <= span_next;
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.fire)
        begin
            ok_reg     <= evt.ok;
            unwrap_reg <= unwrap_next;
        end
    end

    assign out_valid     = valid_reg;
    assign frame_ok      = ok_reg;
    assign held_words    = held_reg;
    assign sample_index  = index_reg;
    assign unwrapped_yaw = unwrap_reg;

endmodule

[rtl/imu_frame_decode_yaw_unwrap.sv]
// top level: imu frame decoder with checksum, held values and yaw unwrap
// depends on ifdyu_pkg, ifdyu_if, ifdyu_assemble, ifdyu_unwrap
//
//   channel   dir   word                                   accepted when
//   byte_ch   in    data_byte, frame_start                 valid & ready
//   result    out   frame_ok, nine words, index, unwrapped valid & ready
//   cfg       in    yaw_offset                             valid & ready
//
// one byte per cycle while byte_ch.ready is high; a frame's result appears in the cycle after its last byte
// the result register is the only buffer: byte_ch.ready drops only while a
// result waits and result.ready is low
// cfg.ready is always high
// rst_n clears position, sum, held values, turn count and offset at once

module imu_frame_decode_yaw_unwrap (
    input  logic         clk,
    input  logic         rst_n,
    imu_byte_if.sink     byte_ch,
    imu_result_if.source result,
    imu_cfg_if.sink      cfg
);
    import ifdyu_pkg::*;

    frame_evt_t                 evt;
    held_words_t                held_words;
    logic                       accept;
    logic signed [OFFSET_W-1:0] offset_reg;

    assign byte_ch.ready = !result.valid || result.ready;
    assign accept        = byte_ch.valid && byte_ch.ready;
    assign cfg.ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else if (cfg.valid)
        begin
            offset_reg <= cfg.yaw_offset;
        end
    end

    ifdyu_assemble u_assemble (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (byte_ch.data_byte),
        .frame_start (byte_ch.frame_start),
        .evt         (evt)
    );

    ifdyu_unwrap u_unwrap (
        .clk           (clk),
        .rst_n         (rst_n),
        .evt           (evt),
        .yaw_offset    (offset_reg),
        .out_ready     (result.ready),
        .out_valid     (result.valid),
        .frame_ok      (result.frame_ok),
        .held_words    (held_words),
        .sample_index  (result.sample_index),
        .unwrapped_yaw (result.unwrapped_yaw)
    );

    assign result.roll        = signed'(held_words[0]);
    assign result.pitch       = signed'(held_words[1]);
    assign result.yaw         = signed'(held_words[2]);
    assign result.roll_speed  = signed'(held_words[3]);
    assign result.pitch_speed = signed'(held_words[4]);
    assign result.yaw_speed   = signed'(held_words[5]);
    assign result.accel_x     = signed'(held_words[6]);
    assign result.accel_y     = signed'(held_words[7]);
    assign result.accel_z     = signed'(held_words[8]);

endmodule

[rtl/ifdyu_check.sv]
// port-level checker for imu_frame_decode_yaw_unwrap, attached by bind
// depends on the top level's ports only

module ifdyu_check (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_ok,
    input logic [31:0] out_unwrapped,
    input logic        cfg_ready
);

    // a waiting result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_ok) && $stable(out_unwrapped))
        else $error("result changed while stalled");

    // input only stalls behind a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a waiting result");

    // every new result follows an accepted byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !$past(out_valid && !out_ready) |-> $past(in_valid && in_ready))
        else $error("result without an accepted byte");

    // config port never blocks
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind imu_frame_decode_yaw_unwrap ifdyu_check u_ifdyu_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (byte_ch.valid),
    .in_ready      (byte_ch.ready),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .out_ok        (result.frame_ok),
    .out_unwrapped (result.unwrapped_yaw),
    .cfg_ready     (cfg.ready)
);

[dv/tb_imu_frame_decode_yaw_unwrap.sv]
// testbench for the imu frame decoder with yaw unwrap: directed frames, random byte traffic
// under several stall mixes and a turn counter sweep, each result checked against a predictor
// depends on rtl/ifdyu_pkg.sv, rtl/ifdyu_if.sv and rtl/imu_frame_decode_yaw_unwrap.sv

module tb_imu_frame_decode_yaw_unwrap;
    timeunit 1ns;
    timeprecision 1ps;

    import ifdyu_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int PHASE_BYTES   = 200;
    localparam int PRESSURE_HOLD = 400;
    localparam int QUEUE_LOW     = 64;
    localparam int CLIMB_TURNS   = 3;
    localparam int DESCENT_TURNS = 5;
    localparam int DIRECTED_ROWS = 25;

    typedef struct packed {
        logic        frame_ok;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic signed [15:0] roll_speed;
        logic signed [15:0] pitch_speed;
        logic signed [15:0] yaw_speed;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic [7:0]         sample_index;
        logic signed [UNWRAP_W-1:0] unwrapped_yaw;
    } frame_result_t;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       pinned;
    } byte_word_t;

    // extremes and values around zero in the words, first byte unmarked right after reset
    localparam byte_word_t DIRECTED [DIRECTED_ROWS] = '{
        '{8'hff, 1'b0, 1'b0}, '{8'h7f, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0}, '{8'h80, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0}, '{8'h80, 1'b0, 1'b0},
        '{8'hff, 1'b0, 1'b0}, '{8'hff, 1'b0, 1'b0},
        '{8'h01, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0},
        '{8'hff, 1'b0, 1'b0}, '{8'h7f, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0}, '{8'h80, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0},
        '{8'hff, 1'b0, 1'b0}, '{8'h7f, 1'b0, 1'b0},
        '{8'hff, 1'b0, 1'b0},
        '{8'hf8, 1'b0, 1'b1},
        // stray byte after a complete frame, then a mark in mid-frame
        '{8'ha5, 1'b0, 1'b0},
        '{8'h5a, 1'b1, 1'b0}, '{8'h00, 1'b0, 1'b0},
        '{8'hff, 1'b1, 1'b0}, '{8'h00, 1'b0, 1'b0}
    };

    localparam frame_result_t EXTREME_FRAME = '{
        frame_ok:      1'b1,
        roll:          16'sh7fff,
        pitch:         16'sh8000,
        yaw:           16'sh8000,
        roll_speed:    16'shffff,
        pitch_speed:   16'sh0001,
        yaw_speed:     16'sh7fff,
        accel_x:       16'sh8000,
        accel_y:       16'sh0000,
        accel_z:       16'sh7fff,
        sample_index:  8'hff,
        unwrapped_yaw: -32'sd32768
    };

    logic clk;
    logic rst_n = 1'b0;

    imu_byte_if   byte_ch ();
    imu_result_if result ();
    imu_cfg_if    cfg ();

    imu_frame_decode_yaw_unwrap i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .result  (result),
        .cfg     (cfg)
    );

    // decoder state mirror
    int                          frame_pos;
    logic [7:0]                  frame_sum;
    logic [7:0]                  staged [SUM_BYTES];
    logic signed [15:0]          held_word [WORD_COUNT];
    logic [7:0]                  held_index_q;
    logic signed [15:0]          last_yaw;
    logic signed [TURN_BITS-1:0] turn_ct;
    logic signed [OFFSET_W-1:0]  offset_cur;

    byte_word_t    stim_q [$];
    frame_result_t pending_results [$];

    bit holding;
    bit pressure_armed;
    int send_idle_pct;
    int recv_stall_pct;
    int errors;
    int results_seen;
    int bytes_taken;
    int offsets_written;
    int cycle_count;
    int turn_hi;
    int turn_lo;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_imu_frame_decode_yaw_unwrap failed");
        $finish;
    end

    function automatic bit decode_byte(input logic [7:0] b, input logic st,
                                       output frame_result_t r);
        logic signed [15:0] yaw_now;
        r = '0;
        if (st)
        begin
            frame_pos = 0;
            frame_sum = '0;
        end
        if (frame_pos >= FRAME_BYTES)
            return 1'b0;
        if (frame_pos < SUM_BYTES)
        begin
            staged[frame_pos] = b;
            frame_sum = frame_sum + b;
            frame_pos++;
            return 1'b0;
        end
        frame_pos = FRAME_BYTES;
        r.frame_ok = (frame_sum == b);
        if (r.frame_ok)
        begin
            for (int w = 0; w < WORD_COUNT; w++)
                held_word[w] = {staged[2*w+1], staged[2*w]};
            held_index_q = staged[SUM_BYTES-1];
        end
        yaw_now = held_word[YAW_WORD];
        if (yaw_now < -WRAP_LIMIT)
        begin
            if (last_yaw > WRAP_LIMIT && turn_ct != TURN_MAX)
                turn_ct++;
        end
        else if (yaw_now > WRAP_LIMIT)
        begin
            if (last_yaw < -WRAP_LIMIT && turn_ct != TURN_MIN)
                turn_ct--;
        end
        last_yaw = yaw_now;
        if (int'(turn_ct) > turn_hi)
            turn_hi = int'(turn_ct);
        if (int'(turn_ct) < turn_lo)
            turn_lo = int'(turn_ct);
        r.roll          = held_word[0];
        r.pitch         = held_word[1];
        r.yaw           = held_word[2];
        r.roll_speed    = held_word[3];
        r.pitch_speed   = held_word[4];
        r.yaw_speed     = held_word[5];
        r.accel_x       = held_word[6];
        r.accel_y       = held_word[7];
        r.accel_z       = held_word[8];
        r.sample_index  = held_index_q;
        r.unwrapped_yaw = int'(yaw_now) + int'(turn_ct) * TURN_SPAN + int'(offset_cur);
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got)
        begin
            errors++;
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // byte sender; the predictor runs on every accepted word
    initial begin
        byte_word_t    cur;
        frame_result_t predicted;
        cur = '0;
        holding = 1'b0;
        byte_ch.valid       <= 1'b0;
        byte_ch.data_byte   <= '0;
        byte_ch.frame_start <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (byte_ch.valid && byte_ch.ready)
            begin
                if (decode_byte(cur.data, cur.start, predicted))
                    pending_results.push_back(cur.pinned ? EXTREME_FRAME : predicted);
                holding = 1'b0;
                bytes_taken++;
            end
            if (!holding && stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cur = stim_q.pop_front();
                holding = 1'b1;
            end
            byte_ch.valid       <= holding;
            byte_ch.data_byte   <= cur.data;
            byte_ch.frame_start <= cur.start;
        end
    end

    // result receiver with its own long hold-off counter
    initial begin
        int hold_left;
        hold_left = 0;
        result.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pressure_armed)
            begin
                pressure_armed = 1'b0;
                hold_left = PRESSURE_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result.ready <= 1'b0;
            end
            else
                result.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        frame_result_t got;
        frame_result_t want;
        if (rst_n && result.valid && result.ready)
        begin
            got.frame_ok      = result.frame_ok;
            got.roll          = result.roll;
            got.pitch         = result.pitch;
            got.yaw           = result.yaw;
            got.roll_speed    = result.roll_speed;
            got.pitch_speed   = result.pitch_speed;
            got.yaw_speed     = result.yaw_speed;
            got.accel_x       = result.accel_x;
            got.accel_y       = result.accel_y;
            got.accel_z       = result.accel_z;
            got.sample_index  = result.sample_index;
            got.unwrapped_yaw = result.unwrapped_yaw;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result: expected none, actual unwrapped_yaw %0d",
                         $time, got.unwrapped_yaw);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("frame_ok", want.frame_ok, got.frame_ok);
                check_field("roll", want.roll, got.roll);
                check_field("pitch", want.pitch, got.pitch);
                check_field("yaw", want.yaw, got.yaw);
                check_field("roll_speed", want.roll_speed, got.roll_speed);
                check_field("pitch_speed", want.pitch_speed, got.pitch_speed);
                check_field("yaw_speed", want.yaw_speed, got.yaw_speed);
                check_field("accel_x", want.accel_x, got.accel_x);
                check_field("accel_y", want.accel_y, got.accel_y);
                check_field("accel_z", want.accel_z, got.accel_z);
                check_field("sample_index", want.sample_index, got.sample_index);
                check_field("unwrapped_yaw", want.unwrapped_yaw, got.unwrapped_yaw);
            end
        end
    end

    task automatic wait_drain();
        while (stim_q.size() != 0 || holding || pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_offset(input logic signed [OFFSET_W-1:0] value);
        @(posedge clk);
        cfg.valid      <= 1'b1;
        cfg.yaw_offset <= value;
        do
            @(posedge clk);
        while (!(cfg.valid && cfg.ready));
        cfg.valid <= 1'b0;
        offset_cur = value;
        offsets_written++;
    endtask

    function automatic logic signed [15:0] pick_yaw();
        case ($urandom_range(7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return $urandom_range(1) ? WRAP_LIMIT : -WRAP_LIMIT;
            3: return $urandom_range(1) ? WRAP_LIMIT + 16'sd1 : -WRAP_LIMIT - 16'sd1;
            4: return 16'($urandom_range(32767, 15001));
            5: return -16'($urandom_range(32768, 15001));
            6: return 16'($urandom_range(30000) - 15000);
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic queue_frame(input logic signed [15:0] yaw_val, input bit good_sum,
                               input int keep, input bit marked);
        logic [7:0] fb [FRAME_BYTES];
        logic [7:0] total;
        total = '0;
        for (int i = 0; i < SUM_BYTES; i++)
            fb[i] = 8'($urandom());
        fb[2*YAW_WORD]   = yaw_val[7:0];
        fb[2*YAW_WORD+1] = yaw_val[15:8];
        for (int i = 0; i < SUM_BYTES; i++)
            total = total + fb[i];
        fb[SUM_BYTES] = good_sum ? total : total + 8'($urandom_range(255, 1));
        while (stim_q.size() > QUEUE_LOW)
            @(posedge clk);
        for (int i = 0; i < keep; i++)
            stim_q.push_back(byte_word_t'{fb[i], marked && i == 0, 1'b0});
    endtask

    task automatic random_traffic(input int n);
        int sent;
        int pick;
        int keep;
        sent = 0;
        while (sent < n)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                // truncated frame, dropped by the next mark
                keep = $urandom_range(SUM_BYTES, 1);
                queue_frame(pick_yaw(), 1'b1, keep, 1'b1);
                sent += keep;
            end
            else if (pick < 14)
            begin
                keep = $urandom_range(4, 1);
                repeat (keep)
                    stim_q.push_back(byte_word_t'{8'($urandom()), 1'b0, 1'b0});
                sent += keep;
            end
            else if (pick < 18)
            begin
                queue_frame(pick_yaw(), 1'($urandom_range(1)), FRAME_BYTES, 1'b0);
                sent += FRAME_BYTES;
            end
            else
            begin
                queue_frame(pick_yaw(), $urandom_range(99) < 85, FRAME_BYTES, 1'b1);
                sent += FRAME_BYTES;
            end
        end
    endtask

    task automatic run_phase(input logic signed [OFFSET_W-1:0] offset_val,
                             input int send_pct, input int recv_pct, input bit squeeze);
        write_offset(offset_val);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (squeeze)
        begin
            @(negedge clk);
            pressure_armed = 1'b1;
        end
        random_traffic(PHASE_BYTES);
        wait_drain();
    endtask

    initial begin
        cfg.valid      <= 1'b0;
        cfg.yaw_offset <= '0;
        frame_pos    = 0;
        frame_sum    = '0;
        held_index_q = '0;
        last_yaw     = '0;
        turn_ct      = '0;
        offset_cur   = '0;
        foreach (held_word[w])
            held_word[w] = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge rst_n);

        for (int k = 0; k < DIRECTED_ROWS; k++)
            stim_q.push_back(DIRECTED[k]);
        wait_drain();

        run_phase(OFFSET_W'(36000), 0, 0, 1'b0);
        run_phase(OFFSET_W'(-36000), 68, 0, 1'b0);
        run_phase(OFFSET_W'(-1), 0, 68, 1'b0);
        run_phase(OFFSET_W'(int'($urandom_range(72000)) - 36000), 23, 23, 1'b0);
        run_phase(OFFSET_W'(0), 0, 0, 1'b1);

        // climb then descend the turn counter
        write_offset(OFFSET_W'(int'($urandom_range(72000)) - 36000));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (CLIMB_TURNS)
        begin
            queue_frame(16'($urandom_range(32767, 15001)), 1'b1, FRAME_BYTES, 1'b1);
            queue_frame(-16'($urandom_range(32768, 15001)), 1'b1, FRAME_BYTES, 1'b1);
            queue_frame(16'($urandom_range(30000) - 15000), 1'b1, FRAME_BYTES, 1'b1);
        end
        repeat (DESCENT_TURNS)
        begin
            queue_frame(-16'($urandom_range(32768, 15001)), 1'b1, FRAME_BYTES, 1'b1);
            queue_frame(16'($urandom_range(32767, 15001)), 1'b1, FRAME_BYTES, 1'b1);
            queue_frame(16'($urandom_range(30000) - 15000), 1'b1, FRAME_BYTES, 1'b1);
        end
        wait_drain();

        $display("run covered %0d bytes, %0d frame results, %0d offset writes",
                 bytes_taken, results_seen, offsets_written);
        $display("turn counter ranged from %0d to %0d", turn_lo, turn_hi);
        if (errors == 0)
            $display("tb_imu_frame_decode_yaw_unwrap passed");
        else
            $display("tb_imu_frame_decode_yaw_unwrap failed");
        $finish;
    end

endmodule
